FILE: hdl/rwcs_pkg.sv
// Shared types, constants and register map of the RGB waveform column shader.
// Depends on nothing; every other file takes what it needs by scoped names.
`timescale 1ns / 1ps

package rwcs_pkg;

   localparam int COLUMNS_DEFAULT = 4096;
   localparam int JOB_DEPTH       = 2;
   localparam int BAR_DEPTH       = 4;

   // divider geometry: color dividends reach 43 bits, height quotients 13 bits
   localparam int QUOT_W     = 13;
   localparam int DIVIDEND_W = 44;
   localparam int DIVISOR_W  = 35;

   localparam logic [7:0] GHOST_GREY = 8'd71;

   localparam int MODE_SPLIT = 0;
   localparam int MODE_SLIP  = 1;
   localparam int MODE_GHOST = 2;

   localparam logic [23:0] LOW_COLOR_RESET    = 24'hFF0000;
   localparam logic [23:0] MID_COLOR_RESET    = 24'h00FF00;
   localparam logic [23:0] HIGH_COLOR_RESET   = 24'h0000FF;
   localparam logic [47:0] GAINS_RESET        = 48'h1000_1000_1000;
   localparam logic [15:0] HEIGHT_SCALE_RESET = 16'h1000;
   localparam logic [10:0] HALF_HEIGHT_RESET  = 11'd64;
   localparam logic [2:0]  MODE_RESET         = 3'b100;

   typedef enum logic [2:0] {
      REG_LOW_COLOR,
      REG_MID_COLOR,
      REG_HIGH_COLOR,
      REG_BAND_GAINS,
      REG_GHOST_GAINS,
      REG_HEIGHT_SCALE,
      REG_HALF_HEIGHT,
      REG_MODE_FLAGS
   } reg_index_type;

   typedef struct packed {
      logic [7:0] level_low;
      logic [7:0] level_mid;
      logic [7:0] level_high;
      logic [7:0] level_all;
      logic       channel;
      logic       contributes;
      logic       column_end;
      logic       frame_start;
   } item_type;

   typedef struct packed {
      logic [11:0] column;
      logic [11:0] bar_top;
      logic [11:0] bar_bottom;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic        is_ghost;
      logic        bar_channel;
      logic        last_bar;
   } bar_type;

   typedef struct packed {
      logic [1:0][7:0] peak_low;
      logic [1:0][7:0] peak_mid;
      logic [1:0][7:0] peak_high;
      logic [1:0][7:0] peak_all;
      logic [11:0]     column;
      logic            split;
      logic            slip;
   } job_type;

   typedef struct packed {
      logic [23:0] low_color;
      logic [23:0] mid_color;
      logic [23:0] high_color;
      logic [47:0] band_gains;
      logic [47:0] ghost_gains;
      logic [15:0] height_scale;
      logic [10:0] half_height;
      logic [2:0]  mode_flags;
   } cfg_type;

endpackage

FILE: hdl/rwcs_fifo.sv
// Small register-based queue, used for column jobs and for finished bars.
// Depends on nothing.
`timescale 1ns / 1ps

module rwcs_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

FILE: hdl/rwcs_front.sv
// Front end: takes entries, tracks per-band peaks and the column counter,
// and hands a snapshot of the peaks to the job queue at column end. Uses rwcs_pkg.
`timescale 1ns / 1ps

module rwcs_front #(
   parameter int COLUMNS = rwcs_pkg::COLUMNS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  rwcs_pkg::item_type item,
   output logic               full,
   input  logic               split_mode,
   input  logic               slip_mode,
   output logic               job_push,
   output rwcs_pkg::job_type  job,
   input  logic               job_full
);
   localparam int CW = $clog2(COLUMNS);

   logic [1:0][7:0] peak_low_ff, peak_mid_ff, peak_high_ff, peak_all_ff;
   logic [1:0][7:0] peak_low_in, peak_mid_in, peak_high_in, peak_all_in;
   logic [CW-1:0]   count_ff, col_cur, col_next;
   logic            slot, accept;

   assign full     = job_full;
   assign accept   = push & ~full;
   assign job_push = accept & item.column_end;

   always_comb begin
      slot         = split_mode & item.channel;
      peak_low_in  = peak_low_ff;
      peak_mid_in  = peak_mid_ff;
      peak_high_in = peak_high_ff;
      peak_all_in  = peak_all_ff;
      if (item.contributes) begin
         if (item.level_low > peak_low_ff[slot]) begin
            peak_low_in[slot] = item.level_low;
         end
         if (item.level_mid > peak_mid_ff[slot]) begin
            peak_mid_in[slot] = item.level_mid;
         end
         if (item.level_high > peak_high_ff[slot]) begin
            peak_high_in[slot] = item.level_high;
         end
         if (item.level_all > peak_all_ff[slot]) begin
            peak_all_in[slot] = item.level_all;
         end
      end
      col_cur  = item.frame_start ? '0 : count_ff;
      col_next = (col_cur == CW'(COLUMNS - 1)) ? '0 : col_cur + 1'b1;

      job.peak_low  = peak_low_in;
      job.peak_mid  = peak_mid_in;
      job.peak_high = peak_high_in;
      job.peak_all  = peak_all_in;
      job.column    = 12'(col_cur);
      job.split     = split_mode;
      job.slip      = slip_mode;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_low_ff  <= '0;
         peak_mid_ff  <= '0;
         peak_high_ff <= '0;
         peak_all_ff  <= '0;
         count_ff     <= '0;
      end else if (accept) begin
         if (item.column_end) begin
            peak_low_ff  <= '0;
            peak_mid_ff  <= '0;
            peak_high_ff <= '0;
            peak_all_ff  <= '0;
            count_ff     <= col_next;
         end else begin
            peak_low_ff  <= peak_low_in;
            peak_mid_ff  <= peak_mid_in;
            peak_high_ff <= peak_high_in;
            peak_all_ff  <= peak_all_in;
            count_ff     <= col_cur;
         end
      end
   end

endmodule

FILE: hdl/rwcs_divider.sv
// Restoring divider, one quotient bit per cycle, saturating quotient.
// Uses rwcs_pkg for its widths.
`timescale 1ns / 1ps

module rwcs_divider (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [rwcs_pkg::DIVIDEND_W-1:0] dividend,
   input  logic [rwcs_pkg::DIVISOR_W-1:0]  divisor,
   output logic                            done,
   output logic [rwcs_pkg::QUOT_W-1:0]     quotient
);
   localparam int QW     = rwcs_pkg::QUOT_W;
   localparam int NW     = rwcs_pkg::DIVIDEND_W;
   localparam int SHW    = rwcs_pkg::DIVISOR_W + QW;
   localparam int STEP_W = $clog2(QW + 1);

   logic [NW-1:0]     rem_ff;
   logic [SHW-1:0]    dsr_ff, diff;
   logic [QW-1:0]     quot_ff;
   logic [STEP_W-1:0] steps_ff;
   logic              run_ff, done_ff, sat, take;

   assign sat      = SHW'(dividend) >= {divisor, {QW{1'b0}}};
   assign take     = SHW'(rem_ff) >= dsr_ff;
   assign diff     = SHW'(rem_ff) - dsr_ff;
   assign done     = done_ff;
   assign quotient = quot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            if (sat) begin
               quot_ff <= '1;
               done_ff <= 1'b1;
               run_ff  <= 1'b0;
            end else begin
               rem_ff   <= dividend;
               dsr_ff   <= SHW'(divisor) << (QW - 1);
               quot_ff  <= '0;
               steps_ff <= STEP_W'(QW);
               run_ff   <= 1'b1;
            end
         end else if (run_ff) begin
            if (take) begin
               rem_ff <= diff[NW-1:0];
            end
            quot_ff  <= {quot_ff[QW-2:0], take};
            dsr_ff   <= dsr_ff >> 1;
            steps_ff <= steps_ff - 1'b1;
            if (steps_ff == STEP_W'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

endmodule

FILE: hdl/rwcs_back.sv
// Back end: per column job, computes the band mix color and bar heights
// and emits ghost and real bars. Uses rwcs_pkg and rwcs_divider.
`timescale 1ns / 1ps

module rwcs_back (
   input  logic              clock,
   input  logic              reset,
   input  rwcs_pkg::cfg_type cfg,
   input  logic              job_empty,
   input  rwcs_pkg::job_type job,
   output logic              job_pop,
   input  logic              bar_full,
   output logic              bar_push,
   output rwcs_pkg::bar_type bar
);
   typedef enum logic [3:0] {
      S_IDLE, S_GAIN, S_MIX, S_MAX, S_CDIV, S_CWAIT,
      S_HPROD, S_HNUM, S_HDIV, S_HWAIT, S_EMIT
   } state_type;

   function automatic logic [7:0] col_byte(input logic [23:0] c, input logic [1:0] k);
      logic [7:0] r;
      case (k)
         2'd0:    r = c[23:16];
         2'd1:    r = c[15:8];
         default: r = c[7:0];
      endcase
      return r;
   endfunction

   state_type         state_ff;
   rwcs_pkg::job_type job_ff;
   logic              chn_ff, ghost_on_ff, ghost_phase_ff;
   logic [1:0]        idx_ff;
   logic [23:0]       gained_ff [3];
   logic [23:0]       gained_in [3];
   logic [25:0]       sg_ff, sg_in, sgh_ff, sgh_in, sel_sum;
   logic [9:0]        sraw_ff, sraw_in;
   logic [33:0]       mix_ff [3];
   logic [33:0]       mix_in, mx_ff, mx_in;
   logic [7:0]        rgb_ff [3];
   logic [23:0]       p_ff, p_in;
   logic [49:0]       num_ff, num_in;
   logic [12:0]       h_ff;
   logic [7:0]        raw [3];
   logic [15:0]       gain [3];
   logic [15:0]       ggain [3];
   logic              ghost_want, two_ch;
   logic              div_start, div_done;
   logic [rwcs_pkg::DIVIDEND_W-1:0] div_dividend, cdvd;
   logic [rwcs_pkg::DIVISOR_W-1:0]  div_divisor;
   logic [rwcs_pkg::QUOT_W-1:0]     div_quot;
   logic [25:0]       x0;
   logic [51:0]       x1;
   logic [13:0]       hh, hsum, bot_raw, hh2;
   logic [13:0]       top_v, bot_v;

   rwcs_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign two_ch = job_ff.split & ~job_ff.slip;

   always_comb begin
      raw[0] = job_ff.peak_low[chn_ff];
      raw[1] = job_ff.peak_mid[chn_ff];
      raw[2] = job_ff.peak_high[chn_ff];
      ghost_want = 1'b0;
      for (int b = 0; b < 3; b++) begin
         gain[b]      = cfg.band_gains[16*b +: 16];
         ggain[b]     = cfg.ghost_gains[16*b +: 16];
         gained_in[b] = 24'(raw[b]) * 24'(gain[b]);
         if (gain[b] < ggain[b]) begin
            ghost_want = 1'b1;
         end
      end
      sg_in   = 26'(gained_in[0]) + 26'(gained_in[1]) + 26'(gained_in[2]);
      sgh_in  = 26'(24'(raw[0]) * 24'(ggain[0])) + 26'(24'(raw[1]) * 24'(ggain[1]))
              + 26'(24'(raw[2]) * 24'(ggain[2]));
      sraw_in = 10'(raw[0]) + 10'(raw[1]) + 10'(raw[2]);

      mix_in = 34'(32'(gained_ff[0]) * 32'(col_byte(cfg.low_color, idx_ff)))
             + 34'(32'(gained_ff[1]) * 32'(col_byte(cfg.mid_color, idx_ff)))
             + 34'(32'(gained_ff[2]) * 32'(col_byte(cfg.high_color, idx_ff)));
      mx_in = (mix_ff[0] > mix_ff[1]) ? mix_ff[0] : mix_ff[1];
      if (mix_ff[2] > mx_in) begin
         mx_in = mix_ff[2];
      end

      // 255 * C / M rounded: (510 C + M) / (2 M)
      cdvd = (rwcs_pkg::DIVIDEND_W'(mix_ff[idx_ff]) << 9)
           - (rwcs_pkg::DIVIDEND_W'(mix_ff[idx_ff]) << 1)
           + rwcs_pkg::DIVIDEND_W'(mx_ff);

      p_in    = 24'(cfg.height_scale) * 24'(job_ff.peak_all[chn_ff]);
      sel_sum = ghost_phase_ff ? sgh_ff : sg_ff;
      num_in  = 50'(p_ff) * 50'(sel_sum);
      x0      = 26'({p_ff, 1'b0}) + 26'(4096);
      x1      = 52'({num_ff, 1'b0}) + (52'(sraw_ff) << 24);

      div_start = (state_ff == S_CDIV) || (state_ff == S_HDIV);
      if (state_ff == S_HDIV) begin
         if (sraw_ff == '0) begin
            // no raw energy: gain ratio is one
            div_dividend = rwcs_pkg::DIVIDEND_W'(x0[25:13]);
            div_divisor  = rwcs_pkg::DIVISOR_W'(1);
         end else begin
            div_dividend = rwcs_pkg::DIVIDEND_W'(x1[51:25]);
            div_divisor  = rwcs_pkg::DIVISOR_W'(sraw_ff);
         end
      end else begin
         div_dividend = cdvd;
         div_divisor  = {mx_ff, 1'b0};
      end

      hh      = 14'(cfg.half_height);
      hh2     = {hh[12:0], 1'b0};
      hsum    = hh + 14'(h_ff);
      // right channel of a split pair grows down from the center line
      if (job_ff.split && chn_ff) begin
         top_v = hh;
      end else begin
         top_v = (14'(h_ff) > hh) ? '0 : hh - 14'(h_ff);
      end
      if (job_ff.split) begin
         bot_raw = chn_ff ? hsum : hh;
      end else begin
         bot_raw = job_ff.slip ? hh : hsum;
      end
      bot_v   = (bot_raw > hh2) ? hh2 : bot_raw;

      bar.column      = job_ff.column;
      bar.bar_top     = top_v[11:0];
      bar.bar_bottom  = bot_v[11:0];
      bar.red         = ghost_phase_ff ? rwcs_pkg::GHOST_GREY : rgb_ff[0];
      bar.green       = ghost_phase_ff ? rwcs_pkg::GHOST_GREY : rgb_ff[1];
      bar.blue        = ghost_phase_ff ? rwcs_pkg::GHOST_GREY : rgb_ff[2];
      bar.is_ghost    = ghost_phase_ff;
      bar.bar_channel = job_ff.split & chn_ff;
      bar.last_bar    = ~ghost_phase_ff & (~two_ch | chn_ff);

      job_pop  = (state_ff == S_IDLE) & ~job_empty;
      bar_push = (state_ff == S_EMIT) & ~bar_full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         ghost_phase_ff <= 1'b0;
         chn_ff         <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (!job_empty) begin
                  job_ff         <= job;
                  chn_ff         <= 1'b0;
                  ghost_phase_ff <= 1'b0;
                  ghost_on_ff    <= ghost_want & cfg.mode_flags[rwcs_pkg::MODE_GHOST];
                  state_ff       <= S_GAIN;
               end
            end
            S_GAIN: begin
               for (int b = 0; b < 3; b++) begin
                  gained_ff[b] <= gained_in[b];
               end
               sg_ff    <= sg_in;
               sgh_ff   <= sgh_in;
               sraw_ff  <= sraw_in;
               idx_ff   <= 2'd0;
               state_ff <= S_MIX;
            end
            S_MIX: begin
               mix_ff[idx_ff] <= mix_in;
               if (idx_ff == 2'd2) begin
                  state_ff <= S_MAX;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            S_MAX: begin
               mx_ff  <= mx_in;
               idx_ff <= 2'd0;
               if (mx_in == '0) begin
                  for (int b = 0; b < 3; b++) begin
                     rgb_ff[b] <= '0;
                  end
                  ghost_phase_ff <= ghost_on_ff;
                  state_ff       <= S_HPROD;
               end else begin
                  state_ff <= S_CDIV;
               end
            end
            S_CDIV: begin
               state_ff <= S_CWAIT;
            end
            S_CWAIT: begin
               if (div_done) begin
                  rgb_ff[idx_ff] <= div_quot[7:0];
                  if (idx_ff == 2'd2) begin
                     ghost_phase_ff <= ghost_on_ff;
                     state_ff       <= S_HPROD;
                  end else begin
                     idx_ff   <= idx_ff + 1'b1;
                     state_ff <= S_CDIV;
                  end
               end
            end
            S_HPROD: begin
               p_ff     <= p_in;
               state_ff <= S_HNUM;
            end
            S_HNUM: begin
               num_ff   <= num_in;
               state_ff <= S_HDIV;
            end
            S_HDIV: begin
               state_ff <= S_HWAIT;
            end
            S_HWAIT: begin
               if (div_done) begin
                  h_ff     <= div_quot;
                  state_ff <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (!bar_full) begin
                  if (ghost_phase_ff) begin
                     ghost_phase_ff <= 1'b0;
                     state_ff       <= S_HPROD;
                  end else if (two_ch && !chn_ff) begin
                     chn_ff   <= 1'b1;
                     state_ff <= S_GAIN;
                  end else begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

FILE: hdl/rgb_waveform_column_shader.sv
// Entries: one per cycle; full rises only while two column jobs wait.
// Column math: per shown channel, three color divisions (none when the mixed
// color is black) and a height pass run in the shared divider; each ghost bar
// adds another height pass.
// Reset (synchronous, active high) clears peaks, counter, queues; loads defaults.
// Top level: register file, front end, job queue, back end, bar queue.
`timescale 1ns / 1ps

module rgb_waveform_column_shader #(
   parameter int COLUMNS = rwcs_pkg::COLUMNS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   input  rwcs_pkg::item_type req_data,
   output logic               req_full,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output rwcs_pkg::bar_type  rsp_data,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [5:0]         csr_paddr,
   input  logic [63:0]        csr_pwdata,
   output logic [63:0]        csr_prdata,
   output logic               csr_pready
);
   rwcs_pkg::cfg_type       cfg_ff;
   rwcs_pkg::reg_index_type reg_idx;
   rwcs_pkg::job_type       job_wr, job_rd;
   rwcs_pkg::bar_type       bar_wr;
   logic                    job_push, job_full, job_pop, job_empty;
   logic                    bar_push, bar_full;
   logic                    csr_wr;

   assign csr_pready = 1'b1;
   assign reg_idx    = rwcs_pkg::reg_index_type'(csr_paddr[5:3]);
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      case (reg_idx)
         rwcs_pkg::REG_LOW_COLOR:    csr_prdata = 64'(cfg_ff.low_color);
         rwcs_pkg::REG_MID_COLOR:    csr_prdata = 64'(cfg_ff.mid_color);
         rwcs_pkg::REG_HIGH_COLOR:   csr_prdata = 64'(cfg_ff.high_color);
         rwcs_pkg::REG_BAND_GAINS:   csr_prdata = 64'(cfg_ff.band_gains);
         rwcs_pkg::REG_GHOST_GAINS:  csr_prdata = 64'(cfg_ff.ghost_gains);
         rwcs_pkg::REG_HEIGHT_SCALE: csr_prdata = 64'(cfg_ff.height_scale);
         rwcs_pkg::REG_HALF_HEIGHT:  csr_prdata = 64'(cfg_ff.half_height);
         rwcs_pkg::REG_MODE_FLAGS:   csr_prdata = 64'(cfg_ff.mode_flags);
         default:                    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.low_color    <= rwcs_pkg::LOW_COLOR_RESET;
         cfg_ff.mid_color    <= rwcs_pkg::MID_COLOR_RESET;
         cfg_ff.high_color   <= rwcs_pkg::HIGH_COLOR_RESET;
         cfg_ff.band_gains   <= rwcs_pkg::GAINS_RESET;
         cfg_ff.ghost_gains  <= rwcs_pkg::GAINS_RESET;
         cfg_ff.height_scale <= rwcs_pkg::HEIGHT_SCALE_RESET;
         cfg_ff.half_height  <= rwcs_pkg::HALF_HEIGHT_RESET;
         cfg_ff.mode_flags   <= rwcs_pkg::MODE_RESET;
      end else if (csr_wr) begin
         case (reg_idx)
            rwcs_pkg::REG_LOW_COLOR:    cfg_ff.low_color    <= csr_pwdata[23:0];
            rwcs_pkg::REG_MID_COLOR:    cfg_ff.mid_color    <= csr_pwdata[23:0];
            rwcs_pkg::REG_HIGH_COLOR:   cfg_ff.high_color   <= csr_pwdata[23:0];
            rwcs_pkg::REG_BAND_GAINS:   cfg_ff.band_gains   <= csr_pwdata[47:0];
            rwcs_pkg::REG_GHOST_GAINS:  cfg_ff.ghost_gains  <= csr_pwdata[47:0];
            rwcs_pkg::REG_HEIGHT_SCALE: cfg_ff.height_scale <= csr_pwdata[15:0];
            rwcs_pkg::REG_HALF_HEIGHT:  cfg_ff.half_height  <= csr_pwdata[10:0];
            rwcs_pkg::REG_MODE_FLAGS:   cfg_ff.mode_flags   <= csr_pwdata[2:0];
            default: ;
         endcase
      end
   end

   rwcs_front #(
      .COLUMNS (COLUMNS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push),
      .item       (req_data),
      .full       (req_full),
      .split_mode (cfg_ff.mode_flags[rwcs_pkg::MODE_SPLIT]),
      .slip_mode  (cfg_ff.mode_flags[rwcs_pkg::MODE_SLIP]),
      .job_push   (job_push),
      .job        (job_wr),
      .job_full   (job_full)
   );

   rwcs_fifo #(
      .WIDTH ($bits(rwcs_pkg::job_type)),
      .DEPTH (rwcs_pkg::JOB_DEPTH)
   ) u_job_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (job_push),
      .wr_data (job_wr),
      .full    (job_full),
      .pop     (job_pop),
      .rd_data (job_rd),
      .empty   (job_empty)
   );

   rwcs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .job_empty (job_empty),
      .job       (job_rd),
      .job_pop   (job_pop),
      .bar_full  (bar_full),
      .bar_push  (bar_push),
      .bar       (bar_wr)
   );

   rwcs_fifo #(
      .WIDTH ($bits(rwcs_pkg::bar_type)),
      .DEPTH (rwcs_pkg::BAR_DEPTH)
   ) u_bar_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (bar_push),
      .wr_data (bar_wr),
      .full    (bar_full),
      .pop     (rsp_pop),
      .rd_data (rsp_data),
      .empty   (rsp_empty)
   );

endmodule

FILE: hdl/rwcs_checker.sv
// Port-level checks for the column shader, bound to the top level.
// Depends on rwcs_pkg and rgb_waveform_column_shader.
`timescale 1ns / 1ps

module rwcs_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_full,
   input logic              rsp_empty,
   input logic              rsp_pop,
   input rwcs_pkg::bar_type rsp_data
);

   // nothing queued right after reset
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   // a ghost bar is never the last bar of a column
   a_ghost_not_last: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_data.is_ghost |-> !rsp_data.last_bar)
      else $error("ghost bar flagged as last");

   // bar spans from top down to bottom
   a_bar_order: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_data.bar_bottom >= rsp_data.bar_top)
      else $error("bar bottom above top");

   // a waiting bar holds until transferred
   a_bar_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_data))
      else $error("waiting bar changed");

endmodule

bind rgb_waveform_column_shader rwcs_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);

FILE: tb/bar_checker.sv
// Bar checker for the RGB waveform column shader: watches the entry, bar and CSR
// channels, predicts each column's bars and compares them field by field.
// Depends on rwcs_pkg for the payload structs, register indexes and reset values.
`timescale 1ns / 1ps

module bar_checker #(
   parameter int COLUMNS = rwcs_pkg::COLUMNS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   input  logic               req_full,
   input  rwcs_pkg::item_type req_data,
   input  logic               rsp_empty,
   input  logic               rsp_pop,
   input  rwcs_pkg::bar_type  rsp_data,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic               csr_pready,
   input  logic [5:0]         csr_paddr,
   input  logic [63:0]        csr_pwdata,
   output int                 fail_count,
   output int                 bars_pending
);

   rwcs_pkg::cfg_type shade_cfg;
   logic [7:0]        peak_lo[2], peak_md[2], peak_hi[2], peak_al[2];
   int unsigned       column_idx;
   rwcs_pkg::bar_type expected_bars[$];

   function automatic longint unsigned gain_at(logic [47:0] packed_gains, int band);
      return longint'(packed_gains[16*band +: 16]);
   endfunction

   function automatic longint unsigned byte_at(logic [23:0] color, int shift);
      return longint'((color >> shift) & 24'hFF);
   endfunction

   function automatic longint unsigned bar_height(longint unsigned sraw,
         longint unsigned sweighted, longint unsigned peak);
      longint unsigned num, den, h;
      if (sraw == 0) begin
         num = longint'(shade_cfg.height_scale) * peak;
         den = 4096;
      end else begin
         num = longint'(shade_cfg.height_scale) * sweighted * peak;
         den = 64'd16777216 * sraw;
      end
      h = (2 * num + den) / (2 * den);
      return (h > 8191) ? 8191 : h;
   endfunction

   function automatic rwcs_pkg::bar_type make_bar(longint unsigned h, int chn, bit split,
         bit slip, longint unsigned r, longint unsigned g, longint unsigned b, bit ghost,
         bit last);
      longint hh, top, bot;
      rwcs_pkg::bar_type bar;
      hh = longint'(shade_cfg.half_height);
      if (!split) begin
         top = hh - longint'(h);
         bot = slip ? hh : hh + longint'(h);
      end else if (chn == 0) begin
         top = hh - longint'(h);
         bot = hh;
      end else begin
         top = hh;
         bot = hh + longint'(h);
      end
      if (top < 0) top = 0;
      if (bot > 2 * hh) bot = 2 * hh;
      bar.column      = column_idx[11:0];
      bar.bar_top     = top[11:0];
      bar.bar_bottom  = bot[11:0];
      bar.red         = r[7:0];
      bar.green       = g[7:0];
      bar.blue        = b[7:0];
      bar.is_ghost    = ghost;
      bar.bar_channel = split ? chn[0] : 1'b0;
      bar.last_bar    = last;
      return bar;
   endfunction

   task automatic shade_entry(rwcs_pkg::item_type it);
      bit split, slip, ghost_on;
      int slot, nch;
      longint unsigned raw[3], wt[3], sraw, swt, sghost, r, g, b, mx;
      split = shade_cfg.mode_flags[rwcs_pkg::MODE_SPLIT];
      slip  = shade_cfg.mode_flags[rwcs_pkg::MODE_SLIP];
      if (it.frame_start) column_idx = 0;
      if (it.contributes) begin
         slot = split ? int'(it.channel) : 0;
         if (it.level_low  > peak_lo[slot]) peak_lo[slot] = it.level_low;
         if (it.level_mid  > peak_md[slot]) peak_md[slot] = it.level_mid;
         if (it.level_high > peak_hi[slot]) peak_hi[slot] = it.level_high;
         if (it.level_all  > peak_al[slot]) peak_al[slot] = it.level_all;
      end
      if (!it.column_end) return;
      ghost_on = 0;
      for (int bd = 0; bd < 3; bd++)
         if (gain_at(shade_cfg.band_gains, bd) < gain_at(shade_cfg.ghost_gains, bd))
            ghost_on = 1;
      ghost_on = ghost_on && shade_cfg.mode_flags[rwcs_pkg::MODE_GHOST];
      nch = (split && !slip) ? 2 : 1;
      for (int chn = 0; chn < nch; chn++) begin
         raw[0] = peak_lo[chn];
         raw[1] = peak_md[chn];
         raw[2] = peak_hi[chn];
         sraw = 0; swt = 0; sghost = 0;
         for (int bd = 0; bd < 3; bd++) begin
            wt[bd] = raw[bd] * gain_at(shade_cfg.band_gains, bd);
            sraw   += raw[bd];
            swt    += wt[bd];
            sghost += raw[bd] * gain_at(shade_cfg.ghost_gains, bd);
         end
         r = wt[0] * byte_at(shade_cfg.low_color, 16) + wt[1] * byte_at(shade_cfg.mid_color, 16)
           + wt[2] * byte_at(shade_cfg.high_color, 16);
         g = wt[0] * byte_at(shade_cfg.low_color, 8) + wt[1] * byte_at(shade_cfg.mid_color, 8)
           + wt[2] * byte_at(shade_cfg.high_color, 8);
         b = wt[0] * byte_at(shade_cfg.low_color, 0) + wt[1] * byte_at(shade_cfg.mid_color, 0)
           + wt[2] * byte_at(shade_cfg.high_color, 0);
         mx = (r > g) ? r : g;
         if (b > mx) mx = b;
         if (mx == 0) begin
            r = 0; g = 0; b = 0;
         end else begin
            r = (510 * r + mx) / (2 * mx);
            g = (510 * g + mx) / (2 * mx);
            b = (510 * b + mx) / (2 * mx);
         end
         if (ghost_on)
            expected_bars.push_back(make_bar(bar_height(sraw, sghost, peak_al[chn]), chn,
               split, slip, rwcs_pkg::GHOST_GREY, rwcs_pkg::GHOST_GREY,
               rwcs_pkg::GHOST_GREY, 1'b1, 1'b0));
         expected_bars.push_back(make_bar(bar_height(sraw, swt, peak_al[chn]), chn,
            split, slip, r, g, b, 1'b0, chn + 1 == nch));
      end
      for (int s = 0; s < 2; s++) begin
         peak_lo[s] = 0; peak_md[s] = 0; peak_hi[s] = 0; peak_al[s] = 0;
      end
      column_idx = (column_idx + 1 >= COLUMNS) ? 0 : column_idx + 1;
   endtask

   task automatic check_field(string fname, longint unsigned exp_v, longint unsigned act_v);
      if (exp_v != act_v) begin
         $display("%0t bar %s mismatch: expected %0d actual %0d", $time, fname, exp_v, act_v);
         fail_count++;
      end
   endtask

   task automatic check_bar(rwcs_pkg::bar_type act);
      rwcs_pkg::bar_type exp_b;
      if (expected_bars.size() == 0) begin
         $display("%0t unexpected bar: expected none actual %h", $time, act);
         fail_count++;
         return;
      end
      exp_b = expected_bars.pop_front();
      check_field("column", exp_b.column, act.column);
      check_field("bar_top", exp_b.bar_top, act.bar_top);
      check_field("bar_bottom", exp_b.bar_bottom, act.bar_bottom);
      check_field("red", exp_b.red, act.red);
      check_field("green", exp_b.green, act.green);
      check_field("blue", exp_b.blue, act.blue);
      check_field("is_ghost", exp_b.is_ghost, act.is_ghost);
      check_field("bar_channel", exp_b.bar_channel, act.bar_channel);
      check_field("last_bar", exp_b.last_bar, act.last_bar);
   endtask

   initial begin
      fail_count   = 0;
      bars_pending = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         shade_cfg.low_color    = rwcs_pkg::LOW_COLOR_RESET;
         shade_cfg.mid_color    = rwcs_pkg::MID_COLOR_RESET;
         shade_cfg.high_color   = rwcs_pkg::HIGH_COLOR_RESET;
         shade_cfg.band_gains   = rwcs_pkg::GAINS_RESET;
         shade_cfg.ghost_gains  = rwcs_pkg::GAINS_RESET;
         shade_cfg.height_scale = rwcs_pkg::HEIGHT_SCALE_RESET;
         shade_cfg.half_height  = rwcs_pkg::HALF_HEIGHT_RESET;
         shade_cfg.mode_flags   = rwcs_pkg::MODE_RESET;
         for (int s = 0; s < 2; s++) begin
            peak_lo[s] = 0; peak_md[s] = 0; peak_hi[s] = 0; peak_al[s] = 0;
         end
         column_idx = 0;
         expected_bars.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready)
            case (rwcs_pkg::reg_index_type'(csr_paddr[5:3]))
               rwcs_pkg::REG_LOW_COLOR:    shade_cfg.low_color    = csr_pwdata[23:0];
               rwcs_pkg::REG_MID_COLOR:    shade_cfg.mid_color    = csr_pwdata[23:0];
               rwcs_pkg::REG_HIGH_COLOR:   shade_cfg.high_color   = csr_pwdata[23:0];
               rwcs_pkg::REG_BAND_GAINS:   shade_cfg.band_gains   = csr_pwdata[47:0];
               rwcs_pkg::REG_GHOST_GAINS:  shade_cfg.ghost_gains  = csr_pwdata[47:0];
               rwcs_pkg::REG_HEIGHT_SCALE: shade_cfg.height_scale = csr_pwdata[15:0];
               rwcs_pkg::REG_HALF_HEIGHT:  shade_cfg.half_height  = csr_pwdata[10:0];
               rwcs_pkg::REG_MODE_FLAGS:   shade_cfg.mode_flags   = csr_pwdata[2:0];
               default: ;
            endcase
         if (req_push && !req_full) shade_entry(req_data);
         if (rsp_pop && !rsp_empty) check_bar(rsp_data);
      end
      bars_pending = expected_bars.size();
   end

endmodule

FILE: tb/tb.sv
// Top of the column shader testbench: clock, reset, entry and CSR stimulus, bar sink.
// Depends on rwcs_pkg, rgb_waveform_column_shader and bar_checker.
`timescale 1ns / 1ps

module tb;

   localparam int CYCLE_LIMIT = 2_000_000;

   logic               clock = 0;
   logic               reset = 1;
   logic               req_push = 0;
   rwcs_pkg::item_type req_data = '0;
   logic               req_full, rsp_empty;
   logic               rsp_pop = 0;
   rwcs_pkg::bar_type  rsp_data;
   logic               csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [5:0]         csr_paddr = '0;
   logic [63:0]        csr_pwdata = '0;
   logic [63:0]        csr_prdata;
   logic               csr_pready;
   int                 fail_count, bars_pending;
   int                 cycles = 0;
   bit                 calm = 0;
   logic               hold_request = 0;
   bit                 hold_done = 0;
   int                 hold_left = 0, pop_gap = 0;

   rgb_waveform_column_shader dut (
      .clock, .reset, .req_push, .req_data, .req_full, .rsp_empty, .rsp_pop, .rsp_data,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata, .csr_prdata,
      .csr_pready
   );

   bar_checker u_checker (
      .clock, .reset, .req_push, .req_full, .req_data, .rsp_empty, .rsp_pop, .rsp_data,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_pready, .csr_paddr, .csr_pwdata,
      .fail_count, .bars_pending
   );

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // bar sink: random gaps after transfers while not calm, one long hold on request
   always @(posedge clock) begin
      int g;
      if (reset) begin
         rsp_pop   <= 0;
         pop_gap   <= 0;
      end else if (hold_request && !hold_done) begin
         hold_done <= 1;
         hold_left <= 1500;
         rsp_pop   <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_pop   <= (hold_left == 1);
      end else if (rsp_pop && !rsp_empty) begin
         g = calm ? 0 : $urandom_range(0, 9);
         pop_gap <= g;
         rsp_pop <= (g == 0);
      end else if (pop_gap > 0) begin
         pop_gap <= pop_gap - 1;
         rsp_pop <= (pop_gap == 1);
      end else begin
         rsp_pop <= 1;
      end
   end

   // called at a rising edge; returns at the edge of the transfer
   task automatic push_entry(rwcs_pkg::item_type it);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_push <= 0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1;
      req_data <= it;
      do @(negedge clock); while (req_full);
      @(posedge clock);
   endtask

   task automatic drain_bars();
      req_push <= 0;
      @(negedge clock);
      while (bars_pending != 0) @(negedge clock);
      repeat (300) @(posedge clock);
   endtask

   // setup and access cycle, then an idle gap so back to back writes stay apart
   task automatic csr_write(rwcs_pkg::reg_index_type idx, logic [63:0] value);
      csr_psel    <= 1;
      csr_penable <= 0;
      csr_pwrite  <= 1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel    <= 0;
      csr_penable <= 0;
      csr_pwrite  <= 0;
      @(posedge clock);
   endtask

   function automatic logic [63:0] pick_value();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic rwcs_pkg::item_type entry(logic [7:0] lv, logic [7:0] md,
         logic [7:0] hv, logic [7:0] al, bit ch, bit contrib, bit col_end, bit fs);
      rwcs_pkg::item_type it;
      it.level_low = lv; it.level_mid = md; it.level_high = hv; it.level_all = al;
      it.channel = ch; it.contributes = contrib; it.column_end = col_end;
      it.frame_start = fs;
      return it;
   endfunction

   function automatic logic [7:0] pick_level();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic rwcs_pkg::item_type random_entry();
      return entry(pick_level(), pick_level(), pick_level(), pick_level(),
                   $urandom_range(0, 1), $urandom_range(0, 9) != 0,
                   $urandom_range(0, 3) == 0, $urandom_range(0, 29) == 0);
   endfunction

   initial begin
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // defaults: full scale, empty column, non-contributing entry, frame start
      push_entry(entry(8'hFF, 8'hFF, 8'hFF, 8'hFF, 0, 1, 1, 0));
      push_entry(entry(8'h00, 8'h00, 8'h00, 8'h00, 0, 1, 1, 0));
      push_entry(entry(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1, 0, 1, 0));
      push_entry(entry(8'h00, 8'h00, 8'h00, 8'h80, 1, 1, 1, 1));
      push_entry(entry(8'h10, 8'h20, 8'h30, 8'hFF, 0, 1, 0, 0));
      push_entry(entry(8'h40, 8'h05, 8'h00, 8'h20, 1, 1, 1, 0));
      drain_bars();

      // ghost on, split stereo, tall panel, big scale
      csr_write(rwcs_pkg::REG_BAND_GAINS, 64'h0800_0400_0200);
      csr_write(rwcs_pkg::REG_GHOST_GAINS, 64'hFFFF_FFFF_FFFF);
      csr_write(rwcs_pkg::REG_HEIGHT_SCALE, 64'hFFFF);
      csr_write(rwcs_pkg::REG_HALF_HEIGHT, 64'd2047);
      csr_write(rwcs_pkg::REG_MODE_FLAGS, 64'd5);
      push_entry(entry(8'hFF, 8'h00, 8'h00, 8'hFF, 0, 1, 0, 0));
      push_entry(entry(8'h00, 8'hFF, 8'h80, 8'h7F, 1, 1, 1, 0));
      push_entry(entry(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1, 1, 1, 0));
      push_entry(entry(8'h00, 8'h00, 8'h00, 8'h00, 0, 0, 1, 0));
      drain_bars();

      // slip single-sided, black low and mid colors, white high color, zero gains, small panel saturates
      csr_write(rwcs_pkg::REG_LOW_COLOR, '0);
      csr_write(rwcs_pkg::REG_MID_COLOR, '0);
      csr_write(rwcs_pkg::REG_HIGH_COLOR, '1);
      csr_write(rwcs_pkg::REG_BAND_GAINS, '0);
      csr_write(rwcs_pkg::REG_HALF_HEIGHT, 64'd3);
      csr_write(rwcs_pkg::REG_MODE_FLAGS, 64'd7);
      push_entry(entry(8'hFF, 8'h01, 8'hFF, 8'hFF, 1, 1, 0, 0));
      push_entry(entry(8'h20, 8'h01, 8'h02, 8'hC0, 0, 1, 1, 0));
      push_entry(entry(8'h20, 8'h01, 8'h02, 8'hC0, 0, 1, 1, 0));
      drain_bars();
      csr_write(rwcs_pkg::REG_MODE_FLAGS, 64'd2);
      push_entry(entry(8'h00, 8'h00, 8'h00, 8'hFF, 0, 1, 1, 0));
      drain_bars();
      // a column left open across a mode change: split slot 1 data, then merged end
      csr_write(rwcs_pkg::REG_MODE_FLAGS, 64'd1);
      push_entry(entry(8'h90, 8'h90, 8'h90, 8'h90, 1, 1, 0, 0));
      drain_bars();
      csr_write(rwcs_pkg::REG_MODE_FLAGS, 64'd0);
      push_entry(entry(8'h10, 8'h11, 8'h12, 8'h13, 0, 1, 1, 0));
      drain_bars();

      // a run of merged one-bar columns, back to back
      csr_write(rwcs_pkg::REG_MODE_FLAGS, 64'd0);
      csr_write(rwcs_pkg::REG_HALF_HEIGHT, 64'd100);
      calm = 1;
      for (int i = 0; i < 20; i++)
         push_entry(entry(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                          0, 1, 1, 0));
      calm = 0;
      drain_bars();

      // back pressure: sink holds off while four-bar columns keep coming
      csr_write(rwcs_pkg::REG_GHOST_GAINS, '1);
      csr_write(rwcs_pkg::REG_BAND_GAINS, 64'h1000_1000_1000);
      csr_write(rwcs_pkg::REG_MODE_FLAGS, 64'd5);
      hold_request <= 1;
      calm = 1;
      for (int i = 0; i < 24; i++)
         push_entry(entry(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                          i[0], 1, 1, 0));
      calm = 0;
      drain_bars();

      // random phases under random register settings
      for (int ph = 0; ph < 8; ph++) begin
         for (int r = 0; r < 8; r++)
            if ($urandom_range(0, 2) != 0)
               csr_write(rwcs_pkg::reg_index_type'(r), pick_value());
         for (int i = 0; i < 50; i++) begin
            if (i % 20 == 0) calm = ($urandom_range(0, 3) == 0);
            push_entry(random_entry());
         end
         calm = 0;
         drain_bars();
      end

      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

FILE: filelist.f
hdl/rwcs_pkg.sv
hdl/rwcs_fifo.sv
hdl/rwcs_front.sv
hdl/rwcs_divider.sv
hdl/rwcs_back.sv
hdl/rgb_waveform_column_shader.sv
hdl/rwcs_checker.sv
tb/bar_checker.sv
tb/tb.sv
